// ===== design/pdr_pkg.sv =====
package pdr_pkg;

    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned RATE_W    = 16;
    localparam int unsigned DT_W      = 16;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned ANGLE_W   = 16;
    localparam int unsigned TRIG_W    = 16;
    localparam int unsigned MAG_W     = 15;
    localparam int unsigned OPA_W     = 33;
    localparam int unsigned OPB_W     = 32;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned MAX_TABLE_BITS = 14;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic signed [OPB_W-1:0] BAM_PER_RAD = 32'sd683565276;
    localparam int unsigned POS_SHIFT  = 25;
    localparam int unsigned HEAD_SHIFT = 44;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TRIG_ONE    = 64'd32767;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SD,
        ST_RD,
        ST_MX,
        ST_MY,
        ST_MH,
        ST_RH,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_SPEED_DT,
        MUL_RATE_DT,
        MUL_SD_COS,
        MUL_SD_SIN,
        MUL_RD_BAM
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     rom_sin;
        logic     load_cos;
        logic     load_sin;
        logic     load_sd;
        logic     load_rd;
        logic     load_step;
        logic     round_head;
        logic     acc_x;
        logic     acc_y;
        logic     acc_h;
    } ctrl_t;

    // quarter-wave entry k, Q30 taylor series to x^11, scaled to 32767
    function automatic logic [MAG_W-1:0] rom_entry(input int unsigned k,
                                                   input int unsigned tb);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        r;
        x  = (HALF_PI_Q30 * 64'(k)) >> tb;
        x2 = (x * x) >> 30;
        s  = $signed(x);
        t  = ((x * x2) >> 30) / 64'd6;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - $signed(t);
        if (s < 0)
        begin
            s = 64'sd0;
        end
        r = ($unsigned(s) * TRIG_ONE + (64'd1 << 29)) >> 30;
        if (r > TRIG_ONE)
        begin
            r = TRIG_ONE;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

// ===== design/planar_pose_dead_reckoning_top.sv =====
// channel   dir   width  contents
// s_*       in    48     tick: forward speed, yaw rate, elapsed time
// m_*       out   80     pose after the tick: x, y, heading
//
// a tick runs from its transfer on s_* through states SD, RD, MX, MY, MH, RH and DONE to the pose on m_*
// a new tick is taken only once the last has run its steps: idle, five multiplier passes, rounding, write-back
// the finished pose waits in an output register, so the next tick can start meanwhile
// a stalled m_* holds the sequencer in its last step until the pose register frees
// reset clears the pose to zero; no start-up pass is needed
module planar_pose_dead_reckoning_top
    import pdr_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,   // forward_speed, yaw_rate, elapsed_time
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata    // pose_x, pose_y, pose_heading
);

    localparam int unsigned TB = (SINE_TABLE_BITS > MAX_TABLE_BITS) ? MAX_TABLE_BITS
                                                                    : SINE_TABLE_BITS;

    ctrl_t                  ctrl;
    logic                   ready;
    logic                   finish;
    logic                   out_free;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_y;
    logic [ANGLE_W-1:0]     heading_new;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    assign out_free = !m_valid_reg || m_tready;

    pdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .ready    (ready),
        .finish   (finish),
        .ctrl     (ctrl)
    );

    pdr_datapath #(
        .TB (TB)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_data     (s_tdata),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading_new (heading_new)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            m_data_reg <= {heading_new, pos_y, pos_x};
        end
    end

    assign s_tready = ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a tick is in flight");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(finish))
        else $error("pose presented without a finished tick");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!m_tvalid || m_tready))
        else $error("pending pose overwritten");

    a_finish_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> s_tready)
        else $error("sequencer not back to idle after finishing");

endmodule

// ===== design/pdr_sine_rom.sv =====
module pdr_sine_rom
    import pdr_pkg::*;
#(
    parameter int unsigned TB = 10
)
(
    input  logic                      clk,
    input  logic [ANGLE_W-1:0]        angle,
    output logic signed [TRIG_W-1:0]  trig
);

    localparam int unsigned DEPTH = (1 << TB) + 1;
    localparam logic [TB:0] FULL  = (TB+1)'(1 << TB);

    logic [MAG_W-1:0] rom_w [0:DEPTH-1];
    logic [TB-1:0]    idx;
    logic [TB:0]      addr;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_rom
        localparam logic [MAG_W-1:0] EntryVal = rom_entry(k, TB);
        assign rom_w[k] = EntryVal;
    end

    // odd quadrants read the table backwards
    assign idx  = angle[ANGLE_W-3 -: TB];
    assign addr = angle[ANGLE_W-2] ? (FULL - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge clk)
    begin
        mag_reg <= rom_w[addr];
        neg_reg <= angle[ANGLE_W-1];
    end

    assign trig = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

// ===== design/pdr_ctrl.sv =====
module pdr_ctrl
    import pdr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_free,
    output logic  ready,
    output logic  finish,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SD;
                end
            end
            ST_SD:   state_next = ST_RD;
            ST_RD:   state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MH;
            ST_MH:   state_next = ST_RH;
            ST_RH:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ready  = 1'b0;
        finish = 1'b0;
        ctrl   = '0;
        ctrl.mul_sel = MUL_SPEED_DT;
        case (state_reg)
            ST_IDLE:
            begin
                ready        = 1'b1;
                ctrl.load_in = in_valid;
            end
            ST_SD:
            begin
                ctrl.mul_sel  = MUL_SPEED_DT;
                ctrl.load_cos = 1'b1;
                ctrl.rom_sin  = 1'b1;
            end
            ST_RD:
            begin
                ctrl.mul_sel  = MUL_RATE_DT;
                ctrl.load_sin = 1'b1;
                ctrl.load_sd  = 1'b1;
            end
            ST_MX:
            begin
                ctrl.mul_sel = MUL_SD_COS;
                ctrl.load_rd = 1'b1;
            end
            ST_MY:
            begin
                ctrl.mul_sel   = MUL_SD_SIN;
                ctrl.load_step = 1'b1;
            end
            ST_MH:
            begin
                ctrl.mul_sel   = MUL_RD_BAM;
                ctrl.load_step = 1'b1;
                ctrl.acc_x     = 1'b1;
            end
            ST_RH:
            begin
                ctrl.load_step  = 1'b1;
                ctrl.round_head = 1'b1;
                ctrl.acc_y      = 1'b1;
            end
            ST_DONE:
            begin
                finish     = out_free;
                ctrl.acc_h = out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/pdr_datapath.sv =====
module pdr_datapath
    import pdr_pkg::*;
#(
    parameter int unsigned TB = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_t                     ctrl,
    input  logic [IN_DATA_W-1:0]      in_data,
    output logic [POS_W-1:0]          pos_x,
    output logic [POS_W-1:0]          pos_y,
    output logic [ANGLE_W-1:0]        heading_new
);

    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic signed [OPA_W-1:0]   sd_reg;
    logic signed [OPA_W-1:0]   rd_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [POS_W-1:0]          step_reg;
    logic [POS_W-1:0]          x_reg;
    logic [POS_W-1:0]          y_reg;
    logic [ANGLE_W-1:0]        h_reg;

    logic [ANGLE_W-1:0]            rom_angle;
    logic signed [TRIG_W-1:0]      trig;
    logic signed [OPA_W-1:0]       mul_a;
    logic signed [OPB_W-1:0]       mul_b;
    logic signed [OPA_W+OPB_W-1:0] prod_full;
    logic signed [PROD_W-1:0]      bias;
    logic signed [PROD_W-1:0]      rsum;
    logic signed [PROD_W-1:0]      rshift;

    assign rom_angle = ctrl.rom_sin ? h_reg : h_reg + QUARTER_TURN;

    pdr_sine_rom #(
        .TB (TB)
    ) u_rom (
        .clk   (clk),
        .angle (rom_angle),
        .trig  (trig)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            MUL_SPEED_DT:
            begin
                mul_a = OPA_W'(speed_reg);
                mul_b = $signed({{(OPB_W-DT_W){1'b0}}, dt_reg});
            end
            MUL_RATE_DT:
            begin
                mul_a = OPA_W'(rate_reg);
                mul_b = $signed({{(OPB_W-DT_W){1'b0}}, dt_reg});
            end
            MUL_SD_COS:
            begin
                mul_a = sd_reg;
                mul_b = OPB_W'(cos_reg);
            end
            MUL_SD_SIN:
            begin
                mul_a = sd_reg;
                mul_b = OPB_W'(sin_reg);
            end
            MUL_RD_BAM:
            begin
                mul_a = rd_reg;
                mul_b = BAM_PER_RAD;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // round half away from zero: negative values take half minus one
    always_comb
    begin
        if (ctrl.round_head)
        begin
            bias = prod_reg[PROD_W-1] ? ((64'sd1 <<< (HEAD_SHIFT-1)) - 64'sd1)
                                      : (64'sd1 <<< (HEAD_SHIFT-1));
        end
        else
        begin
            bias = prod_reg[PROD_W-1] ? ((64'sd1 <<< (POS_SHIFT-1)) - 64'sd1)
                                      : (64'sd1 <<< (POS_SHIFT-1));
        end
        rsum   = prod_reg + bias;
        rshift = ctrl.round_head ? (rsum >>> HEAD_SHIFT) : (rsum >>> POS_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            speed_reg <= $signed(in_data[SPEED_W-1:0]);
            rate_reg  <= $signed(in_data[SPEED_W +: RATE_W]);
            dt_reg    <= in_data[SPEED_W+RATE_W +: DT_W];
        end
        if (ctrl.load_cos)
        begin
            cos_reg <= trig;
        end
        if (ctrl.load_sin)
        begin
            sin_reg <= trig;
        end
        if (ctrl.load_sd)
        begin
            sd_reg <= prod_reg[OPA_W-1:0];
        end
        if (ctrl.load_rd)
        begin
            rd_reg <= prod_reg[OPA_W-1:0];
        end
        if (ctrl.load_step)
        begin
            step_reg <= rshift[POS_W-1:0];
        end
        prod_reg <= prod_full[PROD_W-1:0];
    end

    assign heading_new = h_reg + step_reg[ANGLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            h_reg <= '0;
        end
        else
        begin
            if (ctrl.acc_x)
            begin
                x_reg <= x_reg + step_reg;
            end
            if (ctrl.acc_y)
            begin
                y_reg <= y_reg + step_reg;
            end
            if (ctrl.acc_h)
            begin
                h_reg <= heading_new;
            end
        end
    end

    assign pos_x = x_reg;
    assign pos_y = y_reg;

endmodule

// ===== bench/planar_pose_dead_reckoning_top_tb.sv =====
`timescale 1ns / 100ps

module planar_pose_dead_reckoning_top_tb;
    import pdr_pkg::*;

    localparam int TABLE_BITS   = 10;
    localparam int EFF_BITS     = (TABLE_BITS > MAX_TABLE_BITS) ? MAX_TABLE_BITS : TABLE_BITS;
    localparam int CRUISE_TICKS = 1080;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [ANGLE_W-1:0] heading;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   x;
    } pose_t;

    class pose_checker;
        longint        quarter_wave[0:(1 << MAX_TABLE_BITS)];
        logic [31:0]   x;
        logic [31:0]   y;
        logic [15:0]   heading;
        pose_t         expected_poses[$];
        int            mismatches;

        function new();
            for (int k = 0; k <= (1 << EFF_BITS); k++)
            begin
                quarter_wave[k] = wave_entry(k);
            end
            x          = '0;
            y          = '0;
            heading    = '0;
            mismatches = 0;
        endfunction

        // sine in Q30 by odd series to x^11, each term truncated, scaled to 32767
        function longint wave_entry(int k);
            longint unsigned ang;
            longint unsigned ang2;
            longint unsigned term;
            longint          acc;
            int              n;
            ang  = (HALF_PI_Q30 * longint'(k)) >> EFF_BITS;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = 0;
            n    = 1;
            for (int i = 0; i < 6; i++)
            begin
                if (i % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
                term = (term * ang2) >> 30;
                term = term / (longint'(n + 1) * longint'(n + 2));
                n    = n + 2;
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            acc = longint'(($unsigned(acc) * TRIG_ONE + (64'd1 << 29)) >> 30);
            if (acc > longint'(TRIG_ONE))
            begin
                acc = longint'(TRIG_ONE);
            end
            return acc;
        endfunction

        function longint sine_at(logic [15:0] angle);
            int     idx;
            longint mag;
            idx = int'(angle[13:0]) >> (14 - EFF_BITS);
            mag = angle[14] ? quarter_wave[(1 << EFF_BITS) - idx] : quarter_wave[idx];
            return angle[15] ? -mag : mag;
        endfunction

        // divide by 2^sh, halves rounded away from zero
        function longint round_shift(longint p, int sh);
            longint m;
            longint r;
            m = (p < 0) ? -p : p;
            r = (m + (longint'(1) <<< (sh - 1))) >>> sh;
            return (p < 0) ? -r : r;
        endfunction

        function void advance_pose(logic [15:0] speed, logic [15:0] rate, logic [15:0] dt);
            longint sp;
            longint rt;
            longint tk;
            longint dx;
            longint dy;
            longint dh;
            pose_t  p;
            sp = longint'($signed(speed));
            rt = longint'($signed(rate));
            tk = longint'(dt);
            dx = round_shift(sp * sine_at(heading + QUARTER_TURN) * tk, POS_SHIFT);
            dy = round_shift(sp * sine_at(heading) * tk, POS_SHIFT);
            dh = round_shift(rt * tk * longint'(BAM_PER_RAD), HEAD_SHIFT);
            x       = x + dx[31:0];
            y       = y + dy[31:0];
            heading = heading + dh[15:0];
            p.x       = x;
            p.y       = y;
            p.heading = heading;
            expected_poses.push_back(p);
        endfunction

        function void compare_pose(logic [OUT_DATA_W-1:0] data);
            pose_t got;
            pose_t want;
            got = data;
            if (expected_poses.size() == 0)
            begin
                $display("%0t: pose with none expected: %h", $time, data);
                mismatches++;
                return;
            end
            want = expected_poses.pop_front();
            if (got.x !== want.x)
            begin
                $display("%0t: pose_x expected %0d got %0d", $time,
                         $signed(want.x), $signed(got.x));
                mismatches++;
            end
            if (got.y !== want.y)
            begin
                $display("%0t: pose_y expected %0d got %0d", $time,
                         $signed(want.y), $signed(got.y));
                mismatches++;
            end
            if (got.heading !== want.heading)
            begin
                $display("%0t: pose_heading expected %0d got %0d", $time,
                         want.heading, got.heading);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // forward_speed, yaw_rate, elapsed_time
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // pose_x, pose_y, pose_heading

    pose_checker poses = new();
    int          ticks_sent = 0;
    bit          sender_bursting = 1'b0;

    planar_pose_dead_reckoning_top #(
        .SINE_TABLE_BITS (TABLE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            poses.compare_pose(m_tdata);
        end
    end

    function automatic int pick_gap();
        int r;
        if (sender_bursting)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // extremes turn up often so every bit sees both values
    function automatic logic [15:0] edgy_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_tick(input logic [15:0] speed, input logic [15:0] rate,
                             input logic [15:0] dt);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {dt, rate, speed};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        poses.advance_pose(speed, rate, dt);
        ticks_sent++;
        if (ticks_sent % 50 == 0)
        begin
            sender_bursting = ($urandom_range(0, 2) == 0);
        end
    endtask

    // turn the heading back to about zero so a long straight run piles up on x
    task automatic face_along_x();
        logic signed [15:0] turn;
        longint             rate;
        turn = 16'(16'd0 - poses.heading);
        rate = (longint'(turn) <<< HEAD_SHIFT) / (longint'(65535) * longint'(BAM_PER_RAD));
        send_tick(16'd0, 16'(rate), 16'hFFFF);
    endtask

    // receiver: random stalls, quiet stretches, one long hold-off to back up the input
    initial
    begin
        int  stall_left;
        int  mode_left;
        bit  stalling;
        bit  held;
        stall_left = 0;
        mode_left  = 0;
        stalling   = 1'b0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stalling  = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            if (!held && ticks_sent >= 40)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (stalling && $urandom_range(0, 3) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("planar_pose_dead_reckoning_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send_tick(16'h0000, 16'h0000, 16'h0000);
        send_tick(16'h7FFF, 16'h0000, 16'hFFFF);
        send_tick(16'h8000, 16'h0000, 16'hFFFF);
        send_tick(16'h7FFF, 16'h7FFF, 16'h0000);   // no time passes
        send_tick(16'h7FFF, 16'h7FFF, 16'hFFFF);   // heading step past a full turn
        send_tick(16'h8000, 16'h8000, 16'hFFFF);   // heading goes negative
        send_tick(16'hFFFF, 16'hFFFF, 16'h0001);
        send_tick(16'h0001, 16'h0001, 16'h0001);
        for (int q = 0; q < 5; q++)
        begin
            send_tick(16'd20000, 16'd6434, 16'hFFFF);   // about a quarter turn each
        end
        for (int q = 0; q < 3; q++)
        begin
            send_tick(16'd12000, 16'hE6DE, 16'hFFFF);
        end
        send_tick(16'h5555, 16'h5555, 16'h5555);
        send_tick(16'hAAAA, 16'hAAAA, 16'hAAAA);
        send_tick(16'h8000, 16'h7FFF, 16'h8000);
        send_tick(16'h7FFF, 16'h8000, 16'h7FFF);

        repeat (200)
        begin
            send_tick(edgy_word(), edgy_word(), edgy_word());
        end

        // flat out along x long enough for the position to wrap
        face_along_x();
        repeat (CRUISE_TICKS)
        begin
            send_tick(16'($urandom_range(32500, 32767)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'd0,
                      16'($urandom_range(65000, 65535)));
        end

        repeat (250)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_tick(edgy_word(), 16'($signed(10'($urandom))), 16'($urandom));
            end
            else
            begin
                send_tick(edgy_word(), edgy_word(), edgy_word());
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (poses.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);

        if (poses.mismatches == 0)
        begin
            $display("planar_pose_dead_reckoning_top_tb: done, clean");
        end
        else
        begin
            $display("planar_pose_dead_reckoning_top_tb: done, errors");
        end
        $finish;
    end

endmodule
